// ----- rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants for the frame bump allocator
// Field widths, status codes, register indexes and the front/back packet.
// ----------------------------------------------------------------------------
`default_nettype none
package fba_pkg;
    localparam int FRAME_SLOTS_DEF = 3;
    localparam int MAX_PAGES_DEF   = 8;
    localparam int SLOT_W = 3;
    localparam int PAGE_W = 3;

    localparam logic [31:0] PAGE_GRAIN = 32'h0001_0000;

    localparam logic [31:0] ARENA_RST   = 32'd1;
    localparam logic [31:0] PRIMARY_RST = 32'd4194304;
    localparam logic [31:0] FIRST_RST   = 32'd65536;
    localparam logic [31:0] LIMIT_RST   = 32'd67108864;

    localparam logic [1:0] REG_ARENA   = 2'd0;
    localparam logic [1:0] REG_PRIMARY = 2'd1;
    localparam logic [1:0] REG_FIRST   = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_REQ   = 2'd1,
        ST_BAD_ALIGN = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        status_t           rej_status;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       req;
        logic [31:0]       align;
    } work_t;

    typedef enum logic [3:0] {
        S_IDLE, S_PRIM, S_CLR, S_RD, S_WAIT, S_TRY, S_SUM, S_GEO, S_ROOM,
        S_ADD, S_DONE
    } back_state_t;
endpackage
`default_nettype wire

// ----- rtl/fba_ram.sv -----
// ----------------------------------------------------------------------------
// fba_ram: generic simple dual-port RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/fba_front.sv -----
// ----------------------------------------------------------------------------
// fba_front: request intake and classification
// Checks slot for begin, and slot, size, payload, enable and alignment for
// alloc; holds one classified item for the back end (one-entry queue).
// ----------------------------------------------------------------------------
`default_nettype none
module fba_front #(
    parameter int FRAME_SLOTS = fba_pkg::FRAME_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       operation,
    input  wire logic [fba_pkg::SLOT_W-1:0] frame_slot,
    input  wire logic [31:0]                request_bytes,
    input  wire logic [31:0]                align_bytes,
    input  wire logic                       payload_present,
    input  wire logic                       arena_enabled,
    output logic                            q_valid,
    output fba_pkg::work_t                  q_item,
    input  wire logic                       q_take
);
    logic           q_valid_reg;
    fba_pkg::work_t q_item_reg;
    fba_pkg::work_t cls;
    logic           slot_bad;

    assign slot_bad = {1'b0, frame_slot} >= (fba_pkg::SLOT_W+1)'(FRAME_SLOTS);

    always_comb
    begin
        cls.slot       = frame_slot;
        cls.req        = request_bytes;
        cls.align      = align_bytes;
        cls.rej_status = fba_pkg::ST_OK;
        cls.cmd        = fba_pkg::CMD_ALLOC;
        if (!operation)
        begin
            cls.cmd = fba_pkg::CMD_BEGIN;
            if (slot_bad)
            begin
                cls.cmd        = fba_pkg::CMD_REJECT;
                cls.rej_status = fba_pkg::ST_BAD_REQ;
            end
        end
        else if (!payload_present || slot_bad || request_bytes == 32'd0 || !arena_enabled)
        begin
            cls.cmd        = fba_pkg::CMD_REJECT;
            cls.rej_status = fba_pkg::ST_BAD_REQ;
        end
        else if (align_bytes == 32'd0 || (align_bytes & (align_bytes - 32'd1)) != 32'd0)
        begin
            cls.cmd        = fba_pkg::CMD_REJECT;
            cls.rej_status = fba_pkg::ST_BAD_ALIGN;
        end
    end

    assign in_ready = !q_valid_reg || q_take;
    assign q_valid  = q_valid_reg;
    assign q_item   = q_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            q_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_item_reg <= cls;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/fba_back.sv -----
// ----------------------------------------------------------------------------
// fba_back: allocation engine
// Frame begin clear, primary bump, first-fit page scan, page append, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module fba_back #(
    parameter int FRAME_SLOTS = fba_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_PAGES   = fba_pkg::MAX_PAGES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire fba_pkg::work_t             q_item,
    output logic                            q_take,
    input  wire logic [31:0]                primary_bytes,
    input  wire logic [31:0]                first_spill_page_bytes,
    input  wire logic [31:0]                spill_limit_bytes,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      status,
    output logic                            in_spill,
    output logic [fba_pkg::PAGE_W-1:0]      page_index,
    output logic [34:0]                     region_offset,
    output logic [32:0]                     remaining_bytes
);
    localparam int DEPTH = FRAME_SLOTS * MAX_PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam int IW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

    fba_pkg::back_state_t state_reg, state_next;
    fba_pkg::work_t       item_reg;

    logic [31:0] primary_fill_reg;
    logic [31:0] spill_used_reg;
    logic [PW-1:0] total_reg [FRAME_SLOTS];
    logic [PW-1:0] idx_reg;
    logic [33:0]   acc_reg;
    logic [33:0]   geo_reg;
    logic [33:0]   want_reg;
    logic [31:0]   last_size_reg;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic          in_spill_reg;
    logic [IW-1:0] page_reg;
    logic [34:0]   offset_reg;

    logic          size_we, fill_we;
    logic [AW-1:0] size_wa, fill_wa, raddr;
    logic [31:0]   size_wd, fill_wd, size_rd, fill_rd;
    logic [DEPTH-1:0] fresh_reg;

    fba_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_size (
        .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
        .raddr(raddr), .rdata(size_rd));
    fba_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fill (
        .clk(clk), .we(fill_we), .waddr(fill_wa), .wdata(fill_wd),
        .raddr(raddr), .rdata(fill_rd));

    logic [32:0] amask;
    logic [33:0] prim_at, page_at, page_fill;
    logic        prim_fit, page_fit;
    logic        slot_ok;
    logic        take_ok;
    logic [PW-1:0] n_cur;
    logic [AW-1:0] base_addr;
    logic [32:0] p_left, s_left;
    logic [32:0] used_sum;
    logic [33:0] need, grain, room, limit34;

    assign amask    = {1'b0, item_reg.align} - 33'd1;
    assign prim_at  = ({2'b0, primary_fill_reg} + {1'b0, amask}) & ~{1'b0, amask};
    assign prim_fit = prim_at <= {2'b0, primary_bytes}
                   && {2'b0, item_reg.req} <= {2'b0, primary_bytes} - prim_at;
    // page entries of a slot not yet refilled since begin read as zero fill
    assign page_fill = fresh_reg[raddr] ? 34'd0 : {2'b0, fill_rd};
    assign page_at  = (page_fill + {1'b0, amask}) & ~{1'b0, amask};
    assign page_fit = page_at <= {2'b0, size_rd}
                   && {2'b0, item_reg.req} <= {2'b0, size_rd} - page_at;
    assign slot_ok  = {1'b0, item_reg.slot} < (fba_pkg::SLOT_W+1)'(FRAME_SLOTS);
    assign n_cur    = slot_ok ? total_reg[item_reg.slot[SW-1:0]] : '0;
    assign base_addr = AW'(item_reg.slot * MAX_PAGES);
    assign raddr    = base_addr + AW'(idx_reg);
    assign used_sum = {1'b0, spill_used_reg} + 33'(page_at + {2'b0, item_reg.req} - page_fill);
    assign need     = {2'b0, item_reg.req} + {2'b0, item_reg.align} - 34'd1;
    assign grain    = (need + 34'(fba_pkg::PAGE_GRAIN) - 34'd1) & ~(34'(fba_pkg::PAGE_GRAIN) - 34'd1);
    assign limit34  = {2'b0, spill_limit_bytes};
    assign room     = limit34 > acc_reg ? limit34 - acc_reg : 34'd0;
    assign p_left   = primary_bytes > primary_fill_reg ? {1'b0, primary_bytes - primary_fill_reg} : 33'd0;
    assign s_left   = spill_limit_bytes > spill_used_reg ? {1'b0, spill_limit_bytes - spill_used_reg} : 33'd0;

    assign take_ok = q_valid && (!out_valid_reg || out_ready);
    assign q_take  = (state_reg == fba_pkg::S_IDLE) && take_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fba_pkg::S_IDLE:
                if (take_ok)
                begin
                    state_next = (q_item.cmd == fba_pkg::CMD_ALLOC) ? fba_pkg::S_PRIM :
                                 (q_item.cmd == fba_pkg::CMD_BEGIN) ? fba_pkg::S_CLR :
                                 fba_pkg::S_DONE;
                end
            fba_pkg::S_PRIM:
                state_next = prim_fit ? fba_pkg::S_DONE :
                             (n_cur == '0) ? fba_pkg::S_SUM : fba_pkg::S_RD;
            fba_pkg::S_CLR:  state_next = fba_pkg::S_DONE;
            fba_pkg::S_RD:   state_next = fba_pkg::S_WAIT;
            fba_pkg::S_WAIT: state_next = fba_pkg::S_TRY;
            fba_pkg::S_TRY:
                if (idx_reg < n_cur && page_fit)
                    state_next = fba_pkg::S_DONE;
                else if (idx_reg + PW'(1) < n_cur)
                    state_next = fba_pkg::S_RD;
                else
                    state_next = fba_pkg::S_SUM;
            fba_pkg::S_SUM:
                state_next = (n_cur >= PW'(MAX_PAGES) || need > 34'hFFFF_FFFF) ?
                             fba_pkg::S_DONE : fba_pkg::S_GEO;
            fba_pkg::S_GEO:  state_next = fba_pkg::S_ROOM;
            fba_pkg::S_ROOM:
                state_next = (want_reg >= grain && want_reg != 34'd0) ?
                             fba_pkg::S_ADD : fba_pkg::S_DONE;
            fba_pkg::S_ADD:  state_next = fba_pkg::S_WAIT;
            fba_pkg::S_DONE: state_next = fba_pkg::S_IDLE;
            default: state_next = fba_pkg::S_IDLE;
        endcase
    end

    logic [33:0] want_sel;
    assign want_sel = grain > geo_reg ? grain : geo_reg;

    always_comb
    begin
        size_we = 1'b0;
        size_wa = raddr;
        size_wd = want_reg[31:0];
        fill_we = 1'b0;
        fill_wa = raddr;
        fill_wd = page_at[31:0] + item_reg.req;
        if (state_reg == fba_pkg::S_ADD)
            size_we = 1'b1;
        if (state_reg == fba_pkg::S_TRY && idx_reg < n_cur && page_fit)
            fill_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primary_fill_reg <= '0;
            spill_used_reg   <= '0;
            out_valid_reg    <= 1'b0;
            fresh_reg        <= '0;
            item_reg         <= '0;
            for (int s = 0; s < FRAME_SLOTS; s++)
                total_reg[s] <= '0;
        end
        else
        begin
            if (state_reg == fba_pkg::S_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                fba_pkg::S_IDLE:
                    if (take_ok)
                    begin
                        item_reg <= q_item;
                        idx_reg  <= '0;
                        acc_reg  <= '0;
                        status_reg   <= q_item.rej_status;
                        in_spill_reg <= 1'b0;
                        page_reg     <= '0;
                        offset_reg   <= '0;
                    end
                fba_pkg::S_PRIM:
                    if (prim_fit)
                    begin
                        primary_fill_reg <= prim_at[31:0] + item_reg.req;
                        offset_reg <= 35'(item_reg.slot * {3'b0, primary_bytes}) + 35'(prim_at);
                    end
                fba_pkg::S_CLR:
                begin
                    primary_fill_reg <= '0;
                    spill_used_reg   <= '0;
                    fresh_reg[base_addr +: MAX_PAGES] <= '1;
                end
                fba_pkg::S_TRY:
                begin
                    if (idx_reg < n_cur && page_fit)
                    begin
                        fresh_reg[raddr] <= 1'b0;
                        spill_used_reg <= used_sum[32] ? 32'hFFFF_FFFF : used_sum[31:0];
                        status_reg   <= fba_pkg::ST_OK;
                        in_spill_reg <= 1'b1;
                        page_reg     <= idx_reg[IW-1:0];
                        offset_reg   <= 35'(page_at);
                    end
                    else
                    begin
                        if (idx_reg < n_cur)
                        begin
                            acc_reg <= acc_reg + {2'b0, size_rd};
                            last_size_reg <= size_rd;
                        end
                        idx_reg <= idx_reg + PW'(1);
                        status_reg <= fba_pkg::ST_EXHAUSTED;
                    end
                end
                fba_pkg::S_SUM:
                begin
                    status_reg <= fba_pkg::ST_EXHAUSTED;
                    idx_reg <= n_cur;
                    if (n_cur == '0)
                        geo_reg <= {2'b0, first_spill_page_bytes};
                    else
                        geo_reg <= ({2'b0, last_size_reg} << 1) > limit34 ? limit34
                                   : ({2'b0, last_size_reg} << 1);
                end
                fba_pkg::S_GEO:
                    want_reg <= want_sel > room ? room : want_sel;
                fba_pkg::S_ADD:
                begin
                    total_reg[item_reg.slot[SW-1:0]] <= n_cur + PW'(1);
                    fresh_reg[raddr] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign in_spill        = status_reg == fba_pkg::ST_OK ? in_spill_reg : 1'b0;
    assign page_index      = status_reg == fba_pkg::ST_OK ? fba_pkg::PAGE_W'(page_reg) : '0;
    assign region_offset   = status_reg == fba_pkg::ST_OK ? offset_reg : '0;
    assign remaining_bytes = p_left + s_left;

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> state_reg != fba_pkg::S_IDLE) else $error("take not started");
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        n_cur <= PW'(MAX_PAGES)) else $error("page total over max");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fba_pkg::S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("result lost");
endmodule
`default_nettype wire

// ----- rtl/frame_bump_allocator_with_spill_core.sv -----
// ----------------------------------------------------------------------------
// frame_bump_allocator_with_spill_core: per-frame bump allocator, spill pages
// Front classifies items into a one-entry queue; back allocates.
// ----------------------------------------------------------------------------
//  channel | handshake        | payload
//  in      | in_valid/ready   | operation frame_slot request_bytes align_bytes payload_present
//  out     | out_valid/ready  | status in_spill page_index region_offset remaining_bytes
//  cfg     | APB write/read   | paddr pwdata prdata
// A reject goes straight to the result; begin clears the slot and a primary hit
// bumps the fill first; spill scans pages (page RAM read) and may append a page.
// One item in the back end at a time; it takes the next as the result leaves.
// Reset clears fills and page counts; page RAMs need no clearing.
// A stalled output holds the back end; the front queue still takes one item.
`default_nettype none
module frame_bump_allocator_with_spill_core #(
    parameter int FRAME_SLOTS = fba_pkg::FRAME_SLOTS_DEF,
    parameter int MAX_PAGES   = fba_pkg::MAX_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [2:0]  frame_slot,
    input  wire logic [31:0] request_bytes,
    input  wire logic [31:0] align_bytes,
    input  wire logic        payload_present,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             in_spill,
    output logic [2:0]       page_index,
    output logic [34:0]      region_offset,
    output logic [32:0]      remaining_bytes
);
    logic        arena_reg;
    logic [31:0] primary_reg, first_reg, limit_reg;
    logic        q_valid, q_take;
    fba_pkg::work_t q_item;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg   <= fba_pkg::ARENA_RST[0];
            primary_reg <= fba_pkg::PRIMARY_RST;
            first_reg   <= fba_pkg::FIRST_RST;
            limit_reg   <= fba_pkg::LIMIT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                fba_pkg::REG_ARENA:   arena_reg   <= pwdata[0];
                fba_pkg::REG_PRIMARY: primary_reg <= pwdata;
                fba_pkg::REG_FIRST:   first_reg   <= pwdata;
                fba_pkg::REG_LIMIT:   limit_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fba_pkg::REG_ARENA:   prdata = {31'd0, arena_reg};
            fba_pkg::REG_PRIMARY: prdata = primary_reg;
            fba_pkg::REG_FIRST:   prdata = first_reg;
            fba_pkg::REG_LIMIT:   prdata = limit_reg;
            default:              prdata = '0;
        endcase
    end

    fba_front #(.FRAME_SLOTS(FRAME_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .frame_slot(frame_slot),
        .request_bytes(request_bytes), .align_bytes(align_bytes),
        .payload_present(payload_present), .arena_enabled(arena_reg),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take));

    fba_back #(.FRAME_SLOTS(FRAME_SLOTS), .MAX_PAGES(MAX_PAGES)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .primary_bytes(primary_reg),
        .first_spill_page_bytes(first_reg), .spill_limit_bytes(limit_reg),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .in_spill(in_spill), .page_index(page_index),
        .region_offset(region_offset), .remaining_bytes(remaining_bytes));
endmodule
`default_nettype wire
